// File: src/arm_forward_kinematics_top_macros.svh
// Assertion macros for the arm forward kinematics checker.
// Needs clk and rst_n in the scope that uses them.
`ifndef ARM_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_TOP_MACROS_SVH

// same-cycle implication
`define AFK_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("afk check failed");

// next-cycle implication
`define AFK_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("afk check failed");

`endif

// File: src/afk_pkg.sv
// Package for the arm forward kinematics block: widths, codes, CORDIC table.
// No dependencies.
`default_nettype none
package afk_pkg;

  localparam int ANGLE_W = 16;
  localparam int ANGLE_BITS = 16;
  localparam int Q_W = 16;
  localparam int LEN_W = 24;
  localparam int POS_W = 26;
  localparam int CX_W = 33;
  localparam int CZ_W = 26;
  localparam int CORDIC_N = 16;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int ELBOW_SIGN = 1;
  localparam logic [ANGLE_W-1:0] UPPER_ANGLE_OFFSET = 16'd0;
  localparam logic [ANGLE_W-1:0] FOREARM_ANGLE_OFFSET = 16'd0;
  localparam logic signed [CX_W-1:0] CORDIC_X0 = 33'sd652032874;
  localparam logic [23:0] ANGLE_KEEP = 24'hFFFFFF & ~((24'd1 << (24 - ANGLE_BITS)) - 24'd1);

  typedef enum logic [2:0] {
    REG_SHOULDER_X, REG_SHOULDER_Z, REG_BASE_HEIGHT, REG_UPPER_LEN,
    REG_FOREARM_LEN, REG_JAW_DIST, REG_THROAT_DIST, REG_TIP_DIST
  } cfg_reg_t;

  typedef enum logic [1:0] {ANG_BASE, ANG_UPPER, ANG_FOREARM, ANG_AXIS} angle_sel_t;

  typedef enum logic [2:0] {
    PT_SHOULDER = 3'd0, PT_ELBOW = 3'd1, PT_WRIST = 3'd2,
    PT_JAW = 3'd3, PT_THROAT = 3'd4, PT_TIP = 3'd5
  } point_t;

  typedef struct packed {
    logic       valid;
    angle_sel_t sel;
  } cordic_tag_t;

  // atan(2^-i), 2^24 per turn
  function automatic logic signed [CZ_W-1:0] cordic_atan(input logic [3:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      4'd0:  r = 26'sd2097152;
      4'd1:  r = 26'sd1238021;
      4'd2:  r = 26'sd654136;
      4'd3:  r = 26'sd332050;
      4'd4:  r = 26'sd166669;
      4'd5:  r = 26'sd83416;
      4'd6:  r = 26'sd41718;
      4'd7:  r = 26'sd20860;
      4'd8:  r = 26'sd10430;
      4'd9:  r = 26'sd5215;
      4'd10: r = 26'sd2608;
      4'd11: r = 26'sd1304;
      4'd12: r = 26'sd652;
      4'd13: r = 26'sd326;
      4'd14: r = 26'sd163;
      4'd15: r = 26'sd81;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [ANGLE_W-1:0] elbow_term(input logic [ANGLE_W-1:0] el);
    logic [ANGLE_W-1:0] r;
    if (ELBOW_SIGN > 0) r = el;
    else if (ELBOW_SIGN < 0) r = ~el + 16'd1;
    else r = '0;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [27:0] v);
    logic signed [POS_W-1:0] r;
    if (v > 28'sd33554431) r = 26'sd33554431;
    else if (v < -28'sd33554432) r = -26'sd33554432;
    else r = v[POS_W-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/afk_cordic.sv
// Pipelined CORDIC sine/cosine, one angle per cycle, tag rides along.
// Depends on afk_pkg.
`default_nettype none
module afk_cordic (
  input  logic                          clk,
  input  logic                          rst_n,
  input  afk_pkg::cordic_tag_t          in_tag,
  input  logic [afk_pkg::ANGLE_W-1:0]   in_angle,
  output afk_pkg::cordic_tag_t          out_tag,
  output logic signed [afk_pkg::Q_W-1:0] out_sin,
  output logic signed [afk_pkg::Q_W-1:0] out_cos
);
  import afk_pkg::*;

  logic signed [CX_W-1:0] x_r [0:CORDIC_N];
  logic signed [CX_W-1:0] y_r [0:CORDIC_N];
  logic signed [CZ_W-1:0] z_r [0:CORDIC_N];
  logic                   flip_r [0:CORDIC_N];
  cordic_tag_t            tag_r [0:CORDIC_N];

  logic signed [CX_W-1:0] x_nxt [1:CORDIC_N];
  logic signed [CX_W-1:0] y_nxt [1:CORDIC_N];
  logic signed [CZ_W-1:0] z_nxt [1:CORDIC_N];

  logic [23:0]            a24;
  logic signed [CZ_W-1:0] z_in;
  logic signed [CZ_W-1:0] z0_nxt;
  logic                   flip0_nxt;

  logic signed [CX_W-1:0] rx, ry;
  logic signed [17:0]     qx, qy;
  logic signed [Q_W-1:0]  c_sat, s_sat;
  logic signed [Q_W-1:0]  sin_nxt, cos_nxt;
  cordic_tag_t            out_tag_r;
  logic signed [Q_W-1:0]  sin_r, cos_r;

  always_comb begin
    a24 = {in_angle, 8'd0} & ANGLE_KEEP;
    z_in = CZ_W'($signed(a24));
    if (z_in > 26'sh400000) begin
      z0_nxt = z_in - 26'sh800000;
      flip0_nxt = 1'b1;
    end else if (z_in < -26'sh400000) begin
      z0_nxt = z_in + 26'sh800000;
      flip0_nxt = 1'b1;
    end else begin
      z0_nxt = z_in;
      flip0_nxt = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z_r[i] >= 0) begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - cordic_atan(4'(i));
      end else begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + cordic_atan(4'(i));
      end
    end
  end

  always_comb begin
    rx = x_r[CORDIC_N] + 33'sd16384;
    ry = y_r[CORDIC_N] + 33'sd16384;
    qx = rx[32:15];
    qy = ry[32:15];
    if (qx > 18'sd32767) c_sat = 16'sd32767;
    else if (qx < -18'sd32767) c_sat = -16'sd32767;
    else c_sat = qx[Q_W-1:0];
    if (qy > 18'sd32767) s_sat = 16'sd32767;
    else if (qy < -18'sd32767) s_sat = -16'sd32767;
    else s_sat = qy[Q_W-1:0];
    cos_nxt = flip_r[CORDIC_N] ? -c_sat : c_sat;
    sin_nxt = flip_r[CORDIC_N] ? -s_sat : s_sat;
  end

  always_ff @(posedge clk) begin
    x_r[0] <= CORDIC_X0;
    y_r[0] <= '0;
    z_r[0] <= z0_nxt;
    flip_r[0] <= flip0_nxt;
    for (int i = 1; i <= CORDIC_N; i++) begin
      x_r[i] <= x_nxt[i];
      y_r[i] <= y_nxt[i];
      z_r[i] <= z_nxt[i];
      flip_r[i] <= flip_r[i-1];
    end
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= CORDIC_N; i++) tag_r[i] <= '0;
      out_tag_r <= '0;
    end else begin
      tag_r[0] <= in_tag;
      for (int i = 1; i <= CORDIC_N; i++) tag_r[i] <= tag_r[i-1];
      out_tag_r <= tag_r[CORDIC_N];
    end
  end

  assign out_tag = out_tag_r;
  assign out_sin = sin_r;
  assign out_cos = cos_r;

endmodule
`default_nettype wire

// File: src/arm_forward_kinematics_top.sv
// Arm forward kinematics top: APB registers, angle issue, CORDIC, point pipeline.
// Depends on afk_pkg and afk_cordic.
//
//   channel   signals                          handshake
//   request   start, busy, in_*_angle          start && !busy
//   result    out_valid, out_*                 one-cycle strobe, no backpressure
//   config    psel/penable/pwrite/paddr/...    APB, pready tied high
//
// A new request can be accepted as soon as busy drops, before the previous results
// have left; the six result points go out one per cycle. Four angles enter the shared
// CORDIC pipeline in the order base, upper, forearm, axis.
// Synchronous active-low reset clears the valid bits, sequencer and config registers.
// The result side cannot stall; results leave on fixed cycles.
`default_nettype none
module arm_forward_kinematics_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [afk_pkg::ANGLE_W-1:0]    in_base_angle,
  input  logic [afk_pkg::ANGLE_W-1:0]    in_shoulder_angle,
  input  logic [afk_pkg::ANGLE_W-1:0]    in_elbow_angle,
  output logic                           out_valid,
  output logic [2:0]                     out_point_index,
  output logic signed [afk_pkg::POS_W-1:0] out_pos_x,
  output logic signed [afk_pkg::POS_W-1:0] out_pos_y,
  output logic signed [afk_pkg::POS_W-1:0] out_pos_z,
  output logic                           out_last_point,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [afk_pkg::CFG_AW-1:0]     paddr,
  input  logic [afk_pkg::CFG_DW-1:0]     pwdata,
  output logic [afk_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);
  import afk_pkg::*;

  // config registers
  logic signed [23:0] sh_x_r, sh_z_r, base_h_r, jaw_r, thr_r, tip_r;
  logic [22:0]        up_len_r, fa_len_r;
  cfg_reg_t           cfg_idx;
  logic               cfg_wr;

  assign cfg_idx = cfg_reg_t'(paddr[4:2]);
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'd0 || 1'b1);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_x_r <= '0; sh_z_r <= '0; base_h_r <= '0; up_len_r <= '0;
      fa_len_r <= '0; jaw_r <= '0; thr_r <= '0; tip_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHOULDER_X:  sh_x_r <= pwdata[23:0];
        REG_SHOULDER_Z:  sh_z_r <= pwdata[23:0];
        REG_BASE_HEIGHT: base_h_r <= pwdata[23:0];
        REG_UPPER_LEN:   up_len_r <= pwdata[22:0];
        REG_FOREARM_LEN: fa_len_r <= pwdata[22:0];
        REG_JAW_DIST:    jaw_r <= pwdata[23:0];
        REG_THROAT_DIST: thr_r <= pwdata[23:0];
        REG_TIP_DIST:    tip_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHOULDER_X:  prdata = 32'(sh_x_r);
      REG_SHOULDER_Z:  prdata = 32'(sh_z_r);
      REG_BASE_HEIGHT: prdata = 32'(base_h_r);
      REG_UPPER_LEN:   prdata = {9'd0, up_len_r};
      REG_FOREARM_LEN: prdata = {9'd0, fa_len_r};
      REG_JAW_DIST:    prdata = 32'(jaw_r);
      REG_THROAT_DIST: prdata = 32'(thr_r);
      REG_TIP_DIST:    prdata = 32'(tip_r);
      default:         prdata = '0;
    endcase
  end

  // request issue
  logic [2:0]         cnt_r, cnt_nxt;
  logic               accept;
  logic [ANGLE_W-1:0] up_ang_r, fa_ang_r, ax_ang_r;
  logic [ANGLE_W-1:0] ax_ang, up_ang, fa_ang;
  cordic_tag_t        c_in_tag, c_out_tag;
  logic [ANGLE_W-1:0] c_in_angle;
  logic signed [Q_W-1:0] c_sin, c_cos;

  assign busy = (cnt_r != 3'd0);
  assign accept = start && !busy;
  assign up_ang = in_shoulder_angle + UPPER_ANGLE_OFFSET;
  assign ax_ang = elbow_term(in_elbow_angle) + in_shoulder_angle;
  assign fa_ang = ax_ang + FOREARM_ANGLE_OFFSET;

  always_comb begin
    if (accept) cnt_nxt = 3'd1;
    else if (cnt_r == 3'd5 || cnt_r == 3'd0) cnt_nxt = 3'd0;
    else cnt_nxt = cnt_r + 3'd1;
  end

  always_comb begin
    c_in_tag = '0;
    c_in_angle = in_base_angle;
    if (accept) begin
      c_in_tag = '{valid: 1'b1, sel: ANG_BASE};
    end else begin
      case (cnt_r)
        3'd1: begin c_in_tag = '{valid: 1'b1, sel: ANG_UPPER}; c_in_angle = up_ang_r; end
        3'd2: begin c_in_tag = '{valid: 1'b1, sel: ANG_FOREARM}; c_in_angle = fa_ang_r; end
        3'd3: begin c_in_tag = '{valid: 1'b1, sel: ANG_AXIS}; c_in_angle = ax_ang_r; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      up_ang_r <= up_ang;
      fa_ang_r <= fa_ang;
      ax_ang_r <= ax_ang;
    end
  end

  afk_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tag   (c_in_tag),
    .in_angle (c_in_angle),
    .out_tag  (c_out_tag),
    .out_sin  (c_sin),
    .out_cos  (c_cos)
  );

  // collect sin/cos, hand a full set to the point sequencer
  logic signed [Q_W-1:0] h_bs_r, h_bc_r, h_us_r, h_uc_r, h_fs_r, h_fc_r;
  logic signed [Q_W-1:0] w_bs_r, w_bc_r, w_us_r, w_uc_r, w_fs_r, w_fc_r, w_as_r, w_ac_r;
  logic                  load;
  logic                  emit_r;
  logic [2:0]            ek_r;

  assign load = c_out_tag.valid && (c_out_tag.sel == ANG_AXIS);

  always_ff @(posedge clk) begin
    if (c_out_tag.valid) begin
      case (c_out_tag.sel)
        ANG_BASE:    begin h_bs_r <= c_sin; h_bc_r <= c_cos; end
        ANG_UPPER:   begin h_us_r <= c_sin; h_uc_r <= c_cos; end
        ANG_FOREARM: begin h_fs_r <= c_sin; h_fc_r <= c_cos; end
        default: ;
      endcase
    end
    if (load) begin
      w_bs_r <= h_bs_r; w_bc_r <= h_bc_r;
      w_us_r <= h_us_r; w_uc_r <= h_uc_r;
      w_fs_r <= h_fs_r; w_fc_r <= h_fc_r;
      w_as_r <= c_sin;  w_ac_r <= c_cos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r <= 1'b0;
      ek_r <= '0;
    end else if (load) begin
      emit_r <= 1'b1;
      ek_r <= '0;
    end else if (emit_r) begin
      emit_r <= (ek_r != PT_TIP);
      ek_r <= ek_r + 3'd1;
    end
  end

  // stage 1: link products
  logic signed [LEN_W-1:0] m_len;
  logic signed [Q_W-1:0]   m_s, m_c;
  logic signed [39:0]      prod_x, prod_z, rnd_x, rnd_z;
  logic                    s1_v_r;
  logic [2:0]              s1_k_r;
  logic signed [24:0]      s1_px_r, s1_pz_r;
  logic signed [Q_W-1:0]   s1_bs_r, s1_bc_r;

  always_comb begin
    m_len = '0; m_s = '0; m_c = '0;
    case (point_t'(ek_r))
      PT_ELBOW:  begin m_len = {1'b0, up_len_r}; m_s = w_us_r; m_c = w_uc_r; end
      PT_WRIST:  begin m_len = {1'b0, fa_len_r}; m_s = w_fs_r; m_c = w_fc_r; end
      PT_JAW:    begin m_len = jaw_r; m_s = w_as_r; m_c = w_ac_r; end
      PT_THROAT: begin m_len = thr_r; m_s = w_as_r; m_c = w_ac_r; end
      PT_TIP:    begin m_len = tip_r; m_s = w_as_r; m_c = w_ac_r; end
      default: ;
    endcase
    prod_x = m_len * m_s;
    prod_z = m_len * m_c;
    rnd_x = prod_x + 40'sd16384;
    rnd_z = prod_z + 40'sd16384;
  end

  always_ff @(posedge clk) begin
    s1_k_r <= ek_r;
    s1_px_r <= rnd_x[39:15];
    s1_pz_r <= rnd_z[39:15];
    s1_bs_r <= w_bs_r;
    s1_bc_r <= w_bc_r;
  end

  // stage 2: plane point
  logic signed [26:0]    acc_x_r, acc_z_r, base_px, base_pz, pt_x, pt_z;
  logic                  s2_v_r;
  logic [2:0]            s2_k_r;
  logic signed [26:0]    s2_px_r, s2_pz_r;
  logic signed [Q_W-1:0] s2_bs_r, s2_bc_r;

  always_comb begin
    if (s1_k_r == PT_SHOULDER) begin
      base_px = 27'(sh_x_r);
      base_pz = 27'(sh_z_r);
    end else begin
      base_px = acc_x_r;
      base_pz = acc_z_r;
    end
    pt_x = base_px + 27'(s1_px_r);
    pt_z = base_pz + 27'(s1_pz_r);
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_k_r <= PT_WRIST) begin
      acc_x_r <= pt_x;
      acc_z_r <= pt_z;
    end
    s2_k_r <= s1_k_r;
    s2_px_r <= pt_x;
    s2_pz_r <= pt_z;
    s2_bs_r <= s1_bs_r;
    s2_bc_r <= s1_bc_r;
  end

  // stage 3: base rotation products, height
  logic                  s3_v_r;
  logic [2:0]            s3_k_r;
  logic signed [42:0]    s3_mx_r, s3_my_r;
  logic signed [27:0]    s3_z_r;

  always_ff @(posedge clk) begin
    s3_k_r <= s2_k_r;
    s3_mx_r <= s2_px_r * s2_bc_r;
    s3_my_r <= s2_px_r * s2_bs_r;
    s3_z_r <= 28'(s2_pz_r) + 28'(base_h_r);
  end

  // stage 4: round, saturate, output
  logic signed [42:0]    rnd_mx, rnd_my;
  logic                  out_v_r;
  logic [2:0]            out_k_r;
  logic signed [POS_W-1:0] out_x_r, out_y_r, out_z_r;

  assign rnd_mx = s3_mx_r + 43'sd16384;
  assign rnd_my = s3_my_r + 43'sd16384;

  always_ff @(posedge clk) begin
    out_k_r <= s3_k_r;
    out_x_r <= sat_pos(rnd_mx[42:15]);
    out_y_r <= sat_pos(rnd_my[42:15]);
    out_z_r <= sat_pos(s3_z_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0; s2_v_r <= 1'b0; s3_v_r <= 1'b0; out_v_r <= 1'b0;
    end else begin
      s1_v_r <= emit_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_point_index = out_k_r;
  assign out_pos_x = out_x_r;
  assign out_pos_y = out_y_r;
  assign out_pos_z = out_z_r;
  assign out_last_point = out_v_r && (out_k_r == PT_TIP);

endmodule
`default_nettype wire

// File: src/afk_checker.sv
// Port-level checks for arm_forward_kinematics_top, bound to it below.
// Depends on afk_pkg and arm_forward_kinematics_top_macros.svh.
`default_nettype none
`include "arm_forward_kinematics_top_macros.svh"
module afk_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [2:0]                     out_point_index,
  input logic                           out_last_point,
  input logic                           pready
);
  import afk_pkg::*;

  `AFK_ASSERT_NEXT(a_busy_after_req, start && !busy, busy)
  `AFK_ASSERT_IMPL(a_last_is_tip, out_last_point, out_valid && out_point_index == PT_TIP)
  `AFK_ASSERT_NEXT(a_points_in_order, out_valid && out_point_index != PT_TIP, out_valid && out_point_index == $past(out_point_index) + 3'd1)
  `AFK_ASSERT_IMPL(a_pready_high, 1'b1, pready)

endmodule

bind arm_forward_kinematics_top afk_checker u_afk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_point_index (out_point_index),
  .out_last_point  (out_last_point),
  .pready          (pready)
);
`default_nettype wire
